@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check macros for the RTL files of the rate meter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/eprm_pkg.sv @@
// ----------------------------------------------------------------------------
// eprm_pkg
// Types and fixed constants of the encoder position and rate meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eprm_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CHK,
        S_LAST,
        S_FILL,
        S_SUM,
        S_PREP,
        S_DIV,
        S_SCALE,
        S_OUT
    } t_state;

    // Command codes carried in the input tuser
    localparam logic [1:0] CMD_TIMER  = 2'd0;
    localparam logic [1:0] CMD_ENC    = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TICKS = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_NUM   = 2'd2;
    localparam logic [1:0] CFG_STEP  = 2'd3;

    // Reset values
    localparam logic [31:0] POS_RESET   = 32'h8000_8000;
    localparam logic [15:0] TICKS_RESET = 16'd10000;
    localparam logic [19:0] LIMIT_RESET = 20'd400000;
    localparam logic [31:0] NUM_RESET   = 32'd204800000;
    localparam logic [16:0] STEP_RESET  = 17'd1024;

    // Arithmetic constants
    localparam logic [15:0] SAT16          = 16'hFFFF;
    localparam logic [19:0] SAT20          = 20'hF_FFFF;
    localparam int          QUOT_W         = 32;
    localparam logic [4:0]  DIV_LAST       = 5'd31;
    localparam logic [19:0] RECIP10        = 20'hC_CCCD;  // ceil(2^23 / 10)
    localparam int          RECIP10_SHIFT  = 23;
    localparam logic [19:0] ROUND_HALF     = 20'd5;
    localparam logic [31:0] COARSE_SAT_MIN = 32'd655345;  // (rate+5)/10 >= 0xFFFF

endpackage

`default_nettype wire

@@ rtl/encoder_position_and_rate_meter_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_position_and_rate_meter_unit
// Encoder position tracker and period-averaging rate meter with a shared
// sequencer, a ring memory of periods and a bit-serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// One item is handled at a time; s_axis_tready is high only while idle.
// A timer or encoder beat is executed and the unit returns to idle. A
// sample forms the period sum with one ring read per cycle, then, unless
// the sum is zero, runs a restoring divider that produces one quotient bit
// per cycle. The result beat is held until m_axis_tready is high. The first
// sample after a stop checks the ring and copies the latest period into
// every entry; a sample still waiting for that period returns the held
// rates, and a stopped sample refills the ring with the limit. After reset
// the ring is initialized before the first beat is taken; configuration
// writes are accepted throughout.
module encoder_position_and_rate_meter_unit #(
    parameter int RING_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [15:0] count_value, [16] direction
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] position, [47:32] rate_fine,
                                             // [63:48] rate_coarse
    output logic             m_axis_tuser    // [0] fresh
);
    import eprm_pkg::*;

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = 20 + IW;
    localparam logic [CW-1:0] CNT_LAST = CW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(RING_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(RING_DEPTH - 1);
    localparam logic [IW-1:0] IDX_ONE  = IW'(1);

    // Registers
    t_state          r_state,      n_state;
    logic [15:0]     r_cfg_ticks,  n_cfg_ticks;
    logic [19:0]     r_cfg_limit,  n_cfg_limit;
    logic [31:0]     r_cfg_num,    n_cfg_num;
    logic [16:0]     r_cfg_step,   n_cfg_step;
    logic [31:0]     r_pos_base,   n_pos_base;
    logic [19:0]     r_acc,        n_acc;
    logic [IW-1:0]   r_ring_idx,   n_ring_idx;
    logic            r_refill,     n_refill;
    logic [15:0]     r_held_fine,  n_held_fine;
    logic [15:0]     r_held_coarse, n_held_coarse;
    logic [1:0]      r_cmd,        n_cmd;
    logic [15:0]     r_cnt_val,    n_cnt_val;
    logic            r_dir,        n_dir;
    logic [CW-1:0]   r_cnt,        n_cnt;
    logic [19:0]     r_fill_val,   n_fill_val;
    logic            r_fill_div,   n_fill_div;
    logic [SW-1:0]   r_sum,        n_sum;
    logic [SW-1:0]   r_rem,        n_rem;
    logic [31:0]     r_quot,       n_quot;
    logic [4:0]      r_div_cnt,    n_div_cnt;
    logic [31:0]     r_o_pos,      n_o_pos;
    logic [15:0]     r_o_fine,     n_o_fine;
    logic [15:0]     r_o_coarse,   n_o_coarse;
    logic            r_o_fresh,    n_o_fresh;
    logic [19:0]     r_rd_data;

    // Period ring
    logic [19:0]     ring_mem [RING_DEPTH];
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    logic [19:0]     mem_wd;
    logic [IW-1:0]   mem_ra;

    // Datapath helpers
    logic [20:0]     acc_tick;
    logic [20:0]     per_sum;
    logic [IW-1:0]   last_idx;
    logic [IW-1:0]   next_idx;
    logic [SW-1:0]   sum_addend;
    logic [SW-1:0]   sum_next;
    logic [SW:0]     div_trial;
    logic [SW:0]     div_diff;
    logic            div_ge;
    logic [19:0]     scale_in;
    logic [39:0]     scale_prod;

    assign acc_tick   = {1'b0, r_acc} + {5'b0, r_cfg_ticks};
    assign per_sum    = {1'b0, r_acc} + {5'b0, r_cnt_val};
    assign last_idx   = (r_ring_idx == '0) ? IDX_LAST : r_ring_idx - IW'(1);
    assign next_idx   = (r_ring_idx == IDX_LAST) ? '0 : r_ring_idx + IW'(1);

    // Shared accumulator adder: fill value during refill, ring data otherwise
    assign sum_addend = (r_state == S_FILL) ? SW'(r_fill_val) : SW'(r_rd_data);
    assign sum_next   = r_sum + sum_addend;

    // Restoring divider step
    assign div_trial  = {r_rem, r_quot[QUOT_W-1]};
    assign div_diff   = div_trial - {1'b0, r_sum};
    assign div_ge     = (div_trial >= {1'b0, r_sum});

    // Divide by ten, round half up, via reciprocal multiply
    assign scale_in   = r_quot[19:0] + ROUND_HALF;
    assign scale_prod = {20'b0, scale_in} * {20'b0, RECIP10};

    // Ring memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ring_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= ring_mem[mem_ra];
    end

    // Next state and outputs
    always_comb begin
        n_state       = r_state;
        n_cfg_ticks   = r_cfg_ticks;
        n_cfg_limit   = r_cfg_limit;
        n_cfg_num     = r_cfg_num;
        n_cfg_step    = r_cfg_step;
        n_pos_base    = r_pos_base;
        n_acc         = r_acc;
        n_ring_idx    = r_ring_idx;
        n_refill      = r_refill;
        n_held_fine   = r_held_fine;
        n_held_coarse = r_held_coarse;
        n_cmd         = r_cmd;
        n_cnt_val     = r_cnt_val;
        n_dir         = r_dir;
        n_cnt         = r_cnt;
        n_fill_val    = r_fill_val;
        n_fill_div    = r_fill_div;
        n_sum         = r_sum;
        n_rem         = r_rem;
        n_quot        = r_quot;
        n_div_cnt     = r_div_cnt;
        n_o_pos       = r_o_pos;
        n_o_fine      = r_o_fine;
        n_o_coarse    = r_o_coarse;
        n_o_fresh     = r_o_fresh;
        mem_we        = 1'b0;
        mem_wa        = r_cnt[IW-1:0];
        mem_wd        = r_fill_val;
        mem_ra        = r_cnt[IW-1:0];

        // configuration writes, any time
        if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_TICKS: n_cfg_ticks = i_cfg_data[15:0];
                CFG_LIMIT: n_cfg_limit = i_cfg_data[19:0];
                CFG_NUM:   n_cfg_num   = i_cfg_data;
                CFG_STEP:  n_cfg_step  = i_cfg_data[16:0];
            endcase
        end

        unique case (r_state)
            // ring initialization after reset
            S_INIT: begin
                mem_we = 1'b1;
                mem_wd = LIMIT_RESET;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd     = s_axis_tuser;
                    n_cnt_val = s_axis_tdata[15:0];
                    n_dir     = s_axis_tdata[16];
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_cmd)
                    CMD_TIMER: begin
                        n_acc = (acc_tick >= {1'b0, r_cfg_limit}) ? r_cfg_limit
                                                                  : acc_tick[19:0];
                    end
                    CMD_ENC: begin
                        mem_we     = 1'b1;
                        mem_wa     = r_ring_idx;
                        mem_wd     = per_sum[20] ? SAT20 : per_sum[19:0];
                        n_ring_idx = next_idx;
                        n_acc      = '0;
                        n_pos_base = r_dir ? r_pos_base - {15'b0, r_cfg_step}
                                           : r_pos_base + {15'b0, r_cfg_step};
                    end
                    CMD_SAMPLE: begin
                        n_o_pos = r_pos_base + {16'b0, r_cnt_val};
                        n_cnt   = '0;
                        n_sum   = '0;
                        if (r_acc >= r_cfg_limit) begin
                            // stopped: zero rates, refill ring with the limit
                            n_acc         = r_cfg_limit;
                            n_held_fine   = '0;
                            n_held_coarse = '0;
                            n_ring_idx    = '0;
                            n_refill      = 1'b1;
                            n_fill_val    = r_cfg_limit;
                            n_fill_div    = 1'b0;
                            n_o_fine      = '0;
                            n_o_coarse    = '0;
                            n_o_fresh     = 1'b0;
                            n_state       = S_FILL;
                        end else if (r_refill) begin
                            mem_ra  = IDX_ONE;
                            n_state = S_CHK;
                        end else begin
                            n_state = S_SUM;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            // waiting for the first period after a stop?
            S_CHK: begin
                if (r_rd_data == r_cfg_limit) begin
                    n_o_fine   = r_held_fine;
                    n_o_coarse = r_held_coarse;
                    n_o_fresh  = 1'b0;
                    n_state    = S_OUT;
                end else begin
                    mem_ra  = last_idx;
                    n_state = S_LAST;
                end
            end

            // latest period is copied into every entry
            S_LAST: begin
                n_fill_val = r_rd_data;
                n_fill_div = 1'b1;
                n_refill   = 1'b0;
                n_state    = S_FILL;
            end

            S_FILL: begin
                mem_we = 1'b1;
                n_sum  = sum_next;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = r_fill_div ? S_PREP : S_OUT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            // read one entry per cycle, add the one read last cycle
            S_SUM: begin
                if (r_cnt != '0) begin
                    n_sum = sum_next;
                end
                if (r_cnt == CNT_END) begin
                    n_cnt   = '0;
                    n_state = S_PREP;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            S_PREP: begin
                n_rem     = '0;
                n_quot    = r_cfg_num;
                n_div_cnt = DIV_LAST;
                n_state   = (r_sum == '0) ? S_SCALE : S_DIV;
            end

            S_DIV: begin
                n_rem  = div_ge ? div_diff[SW-1:0] : div_trial[SW-1:0];
                n_quot = {r_quot[QUOT_W-2:0], div_ge};
                if (r_div_cnt == '0) begin
                    n_state = S_SCALE;
                end else begin
                    n_div_cnt = r_div_cnt - 5'd1;
                end
            end

            // saturate fine rate, derive coarse rate
            S_SCALE: begin
                if (r_sum == '0) begin
                    n_o_fine   = SAT16;
                    n_o_coarse = SAT16;
                end else begin
                    n_o_fine   = (r_quot >= {16'b0, SAT16}) ? SAT16 : r_quot[15:0];
                    n_o_coarse = (r_quot >= COARSE_SAT_MIN) ? SAT16
                                 : scale_prod[RECIP10_SHIFT +: 16];
                end
                n_held_fine   = n_o_fine;
                n_held_coarse = n_o_coarse;
                n_o_fresh     = 1'b1;
                n_state       = S_OUT;
            end

            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_cfg_ticks   <= TICKS_RESET;
            r_cfg_limit   <= LIMIT_RESET;
            r_cfg_num     <= NUM_RESET;
            r_cfg_step    <= STEP_RESET;
            r_pos_base    <= POS_RESET;
            r_acc         <= '0;
            r_ring_idx    <= '0;
            r_refill      <= 1'b1;
            r_held_fine   <= '0;
            r_held_coarse <= '0;
            r_cnt         <= '0;
            r_fill_div    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cfg_ticks   <= n_cfg_ticks;
            r_cfg_limit   <= n_cfg_limit;
            r_cfg_num     <= n_cfg_num;
            r_cfg_step    <= n_cfg_step;
            r_pos_base    <= n_pos_base;
            r_acc         <= n_acc;
            r_ring_idx    <= n_ring_idx;
            r_refill      <= n_refill;
            r_held_fine   <= n_held_fine;
            r_held_coarse <= n_held_coarse;
            r_cnt         <= n_cnt;
            r_fill_div    <= n_fill_div;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cnt_val  <= n_cnt_val;
        r_dir      <= n_dir;
        r_fill_val <= n_fill_val;
        r_sum      <= n_sum;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_div_cnt  <= n_div_cnt;
        r_o_pos    <= n_o_pos;
        r_o_fine   <= n_o_fine;
        r_o_coarse <= n_o_coarse;
        r_o_fresh  <= n_o_fresh;
    end

    // Ports
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_o_coarse, r_o_fine, r_o_pos};
    assign m_axis_tuser  = r_o_fresh;

    // Checks
    `CHK_SAME(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "beat taken while result pending")
    `CHK_NEXT(a_busy_after_beat, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready held after input beat")
    `CHK_SAME(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_sum != '0, "divide by zero ring sum")
    `CHK_SAME(a_fresh_refilled, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, !r_refill, "fresh rate with refill pending")

endmodule

`default_nettype wire
